@@ src/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the ring-buffer double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int DATA_W = 32;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // Status codes carried in the output tuser.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

endpackage

@@ src/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // Read data holds until the next read is issued.
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/deq_front.sv @@
// ----------------------------------------------------------------------------
// deq_front
// Input stage: accepts command items, drops unused command codes and holds
// up to two decoded commands for the execution stage.
// ----------------------------------------------------------------------------
module deq_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [deq_pkg::DATA_W-1:0]        i_s_tdata,
    input  logic [deq_pkg::CMD_W-1:0]         i_s_tuser,
    output logic                              o_cmd_valid,
    input  logic                              i_cmd_ready,
    output deq_pkg::t_cmd                     o_cmd
);

    deq_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;

    logic accept;
    logic known;
    logic push;
    logic pop;

    assign o_s_tready  = (r_fill != 2'd2);
    assign accept      = i_s_tvalid && o_s_tready;
    assign known       = i_s_tuser inside {[deq_pkg::CMD_PUSH_FRONT:deq_pkg::CMD_DUMP]};
    assign push        = accept && known;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr].op    <= i_s_tuser;
            r_slot[r_wr_ptr].value <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

@@ src/deq_back.sv @@
// ----------------------------------------------------------------------------
// deq_back
// Execution stage: keeps head and count, drives the entry RAM, walks the
// entries on a dump and holds each result in the output register.
// ----------------------------------------------------------------------------
module deq_back #(
    parameter int CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  deq_pkg::t_cmd                i_cmd,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [deq_pkg::DATA_W-1:0]   o_m_tdata,
    output logic [deq_pkg::STAT_W-1:0]   o_m_tuser,
    output logic                         o_m_tlast
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    localparam logic [IDX_W:0]   CAP_EXT = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

    // Ring addition: both operands are below CAPACITY, so one subtract wraps.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_EXT) begin
            s = s - CAP_EXT;
        end
        return s[IDX_W-1:0];
    endfunction

    logic [1:0]                  r_state,  n_state;
    logic [IDX_W-1:0]            r_head,   n_head;
    logic [CNT_W-1:0]            r_count,  n_count;
    logic [IDX_W-1:0]            r_idx,    n_idx;
    logic                        r_out_valid;
    logic [deq_pkg::DATA_W-1:0]  r_out_data;
    logic [deq_pkg::STAT_W-1:0]  r_out_status;
    logic                        r_out_last;

    logic                        out_free;
    logic                        take;
    logic                        full;
    logic                        empty;
    logic                        dump_last;
    logic [IDX_W-1:0]            head_dec;
    logic [CNT_W-1:0]            cnt_m1;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic [deq_pkg::DATA_W-1:0]  rd_data;

    logic                        load;
    logic [deq_pkg::STAT_W-1:0]  ld_status;
    logic [deq_pkg::DATA_W-1:0]  ld_data;
    logic                        ld_last;

    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign full        = (r_count == CNT_CAP);
    assign empty       = (r_count == '0);
    assign cnt_m1      = r_count - CNT_W'(1);
    assign head_dec    = (r_head == '0) ? IDX_TOP : (r_head - IDX_W'(1));
    assign dump_last   = (CNT_W'(r_idx) == cnt_m1);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        wr_en     = 1'b0;
        wr_addr   = r_head;
        rd_en     = 1'b0;
        rd_addr   = r_head;
        load      = 1'b0;
        ld_status = deq_pkg::STAT_OK;
        ld_data   = '0;
        ld_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_cmd.op)
                        deq_pkg::CMD_PUSH_FRONT: begin
                            load = 1'b1;
                            if (full) begin
                                ld_status = deq_pkg::STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = head_dec;
                                n_head  = head_dec;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        deq_pkg::CMD_PUSH_BACK: begin
                            load = 1'b1;
                            if (full) begin
                                ld_status = deq_pkg::STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = wrap_add(r_head, r_count[IDX_W-1:0]);
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        deq_pkg::CMD_POP_FRONT: begin
                            if (empty) begin
                                load      = 1'b1;
                                ld_status = deq_pkg::STAT_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_head  = wrap_add(r_head, IDX_W'(1));
                                n_count = cnt_m1;
                                n_state = S_POP;
                            end
                        end
                        deq_pkg::CMD_POP_BACK: begin
                            if (empty) begin
                                load      = 1'b1;
                                ld_status = deq_pkg::STAT_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = wrap_add(r_head, cnt_m1[IDX_W-1:0]);
                                n_count = cnt_m1;
                                n_state = S_POP;
                            end
                        end
                        deq_pkg::CMD_DUMP: begin
                            if (empty) begin
                                load      = 1'b1;
                                ld_status = deq_pkg::STAT_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_data = rd_data;
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                // Each entry is loaded while the read of the next one goes out.
                if (out_free) begin
                    load    = 1'b1;
                    ld_data = rd_data;
                    ld_last = dump_last;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = wrap_add(r_head, r_idx + IDX_W'(1));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data   <= ld_data;
            r_out_status <= ld_status;
            r_out_last   <= ld_last;
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_CAP)
        else $error("entry count exceeds capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !full && (i_cmd.op == deq_pkg::CMD_PUSH_FRONT ||
                           i_cmd.op == deq_pkg::CMD_PUSH_BACK))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted push did not grow the queue");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !empty && (i_cmd.op == deq_pkg::CMD_POP_FRONT ||
                            i_cmd.op == deq_pkg::CMD_POP_BACK))
        |=> (r_count == $past(r_count) - CNT_W'(1)) && (r_state == S_POP))
        else $error("accepted pop did not shrink the queue");

    a_dump_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> $stable(r_count) && $stable(r_head))
        else $error("queue changed during a dump");

    a_result_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_cmd.op == deq_pkg::CMD_PUSH_FRONT ||
                  i_cmd.op == deq_pkg::CMD_PUSH_BACK))
        |=> r_out_valid && r_out_last)
        else $error("push gave no result");
`endif

endmodule

@@ src/double_ended_queue_ring.sv @@
// A bounded double-ended queue of signed 32-bit values held in a ring of
// CAPACITY RAM entries, with a head index and an entry count. The input tuser
// carries the command (push front, push back, pop front, pop back, dump) and
// tdata the value to push; unused command codes are accepted and dropped with
// no result. Every push or pop returns one result, and a dump returns one
// result per entry from front to back with tlast on the final one. The output
// tuser carries the status: ok, empty (pop or dump of an empty queue) or full
// (push into a full queue, which changes nothing). A push completes in the
// idle state, a pop waits in a pop state for the registered RAM read, and a
// dump walks the ring through the single read port; a two-entry command
// queue lets input items keep arriving while the execution stage works or
// the output is stalled.
// ----------------------------------------------------------------------------
// double_ended_queue_ring
// Top level: command input stage, execution stage and entry RAM.
// ----------------------------------------------------------------------------
module double_ended_queue_ring #(
    parameter int CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [deq_pkg::DATA_W-1:0]   i_s_tdata,   // [31:0] push_value
    input  logic [deq_pkg::CMD_W-1:0]    i_s_tuser,   // [2:0] command
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [deq_pkg::DATA_W-1:0]   o_m_tdata,   // [31:0] out_value
    output logic [deq_pkg::STAT_W-1:0]   o_m_tuser,   // [1:0] status
    output logic                         o_m_tlast
);

    logic          cmd_valid;
    logic          cmd_ready;
    deq_pkg::t_cmd cmd;

    deq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    deq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
